// File: src/tcw_pkg.sv
// Shared constants, codes and types of the text console writer.
`default_nettype none

package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int TAB_STOP      = 4;
  localparam int CELL_COUNT    = COLUMNS * ROWS;
  localparam int LAST_ROW_HOME = CELL_COUNT - COLUMNS;
  localparam int PH_LAST       = (COLUMNS - 1) % TAB_STOP;

  // Field widths fixed by the interface.
  localparam int KIND_W   = 3;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 8;
  localparam int OFF_W    = 13;
  localparam int ORIGIN_W = 2;
  localparam int POS_W    = 11;
  localparam int STATUS_W = 2;
  localparam int CELL_W   = CHAR_W + COLOR_W;

  // Internal widths derived from the geometry.
  localparam int CUR_W = $clog2(CELL_COUNT);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int PH_W  = $clog2(TAB_STOP);
  localparam int TN_W  = $clog2(TAB_STOP + 1);
  localparam int TGT_W = ((CUR_W > OFF_W) ? CUR_W : OFF_W) + 2;

  localparam logic [CHAR_W-1:0]  BLANK_CHAR  = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h04;

  localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT    = 3'd0,
    KIND_SEEK   = 3'd1,
    KIND_REWIND = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_READ   = 3'd4
  } kind_e;

  typedef enum logic [ORIGIN_W-1:0] {
    ORG_START = 2'd0,
    ORG_CUR   = 2'd1,
    ORG_END   = 2'd2,
    ORG_BAD   = 2'd3
  } origin_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_ORIGIN = 2'd1,
    ST_RANGE      = 2'd2
  } status_e;

  // Request to and response from the column unit.
  typedef struct packed {
    logic             start;
    logic [CUR_W-1:0] pos;
  } tcw_cd_req_t;

  typedef struct packed {
    logic             done;
    logic [COL_W-1:0] col;
    logic [PH_W-1:0]  ph;
  } tcw_cd_rsp_t;

endpackage

`default_nettype wire

// File: src/tcw_col_unit.sv
// Iterative unit that splits a cursor position into its column and tab phase.
`default_nettype none

module tcw_col_unit
  import tcw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire tcw_cd_req_t req_i,
  output tcw_cd_rsp_t      rsp_o
);

  typedef enum logic [1:0] {CD_IDLE, CD_COL, CD_PH} cd_state_e;

  cd_state_e        state_q;
  logic [CUR_W-1:0] rem_q;
  logic [COL_W-1:0] col_q;
  logic             done_q;

  logic [CUR_W-1:0] sub;
  logic [CUR_W-1:0] diff;
  logic             ge;

  // One subtractor serves both the row and the tab-stop reduction.
  always_comb begin
    sub  = (state_q == CD_COL) ? CUR_W'(COLUMNS) : CUR_W'(TAB_STOP);
    ge   = (rem_q >= sub);
    diff = rem_q - sub;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CD_IDLE;
      rem_q   <= '0;
      col_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == CD_PH) && !ge;
      unique case (state_q)
        CD_IDLE: begin
          if (req_i.start) begin
            rem_q   <= req_i.pos;
            state_q <= CD_COL;
          end
        end
        CD_COL: begin
          if (ge) begin
            rem_q <= diff;
          end else begin
            col_q   <= rem_q[COL_W-1:0];
            state_q <= CD_PH;
          end
        end
        CD_PH: begin
          if (ge) begin
            rem_q <= diff;
          end else begin
            state_q <= CD_IDLE;
          end
        end
        default: state_q <= CD_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.col  = col_q;
  assign rsp_o.ph   = rem_q[PH_W-1:0];

endmodule

`default_nettype wire

// File: src/text_console_writer.sv
// Top level of the text console writer: screen memory, cursor and command sequencer.
//
// The block keeps a text screen of ROWS by COLUMNS cells, each a character byte
// and a color byte, plus a linear cursor. Items arrive on the input channel
// (valid/stall); every item yields exactly one result beat on the output
// channel (valid/stall). The color register is written through cfg_we_i.
//
// After reset the block sweeps the screen memory once, one cell per cycle,
// writing a blank in the reset color; in_stall_o is high during the sweep.
// The color register may be written at any time.
//
// From input beat to result beat: carriage return, rewind, unused kinds and a newline
// that does not scroll go straight to the result state; ordinary writes pass through
// the cell write state, backspace through its own state and rejected seeks through
// the seek check. A cell read on the screen adds a wait for the registered memory
// read. A valid seek waits on the column unit, which subtracts COLUMNS per cycle and
// then TAB_STOP per cycle. A scroll sweeps the memory port once, and a clear writes
// every cell once. A tab costs one cell write and one check per space written.
// One item is handled at a time; the next beat waits for the idle state.
// A finished result waits in the output register while the receiver stalls;
// the block still takes the next item and holds its result until the slot frees.
`default_nettype none

module text_console_writer
  import tcw_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration.
  input  wire logic                cfg_we_i,
  input  wire logic [COLOR_W-1:0]  cfg_text_color_i,
  // Input channel.
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [KIND_W-1:0]   kind_i,
  input  wire logic [CHAR_W-1:0]   char_code_i,
  input  wire logic signed [OFF_W-1:0] seek_offset_i,
  input  wire logic [ORIGIN_W-1:0] seek_origin_i,
  input  wire logic [POS_W-1:0]    cell_index_i,
  // Output channel.
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [POS_W-1:0]         cursor_pos_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic                     scrolled_o,
  output logic [CHAR_W-1:0]        cell_char_o,
  output logic [COLOR_W-1:0]       cell_color_o
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_WCELL, S_TAB, S_BS, S_SCR_COPY, S_SCR_BLANK,
    S_SEEK, S_SEEK_WAIT, S_CLR, S_READ, S_READ_WAIT, S_DONE
  } state_e;

  state_e                  state_q;
  logic [COLOR_W-1:0]      text_color_q;
  logic [CUR_W-1:0]        cur_q;
  logic [COL_W-1:0]        col_q;
  logic [PH_W-1:0]         ph_q;
  logic [CUR_W-1:0]        cnt_q;
  logic                    pend_q;
  logic [CUR_W-1:0]        pend_addr_q;
  logic [TN_W-1:0]         tab_n_q;
  logic                    is_tab_q;
  logic [CHAR_W-1:0]       ch_q;
  logic signed [OFF_W-1:0] off_q;
  origin_e                 origin_q;
  logic [POS_W-1:0]        idx_q;
  status_e                 status_q;
  logic                    scr_q;
  logic [CHAR_W-1:0]       rd_char_q;
  logic [COLOR_W-1:0]      rd_color_q;

  logic                    out_valid_q;
  logic [POS_W-1:0]        cursor_pos_q;
  status_e                 status_out_q;
  logic                    scrolled_q;
  logic [CHAR_W-1:0]       cell_char_q;
  logic [COLOR_W-1:0]      cell_color_q;

  // Screen memory: one write and one registered read per cycle.
  logic [CELL_W-1:0] screen_mem [CELL_COUNT];
  logic [CELL_W-1:0] rd_data_q;
  logic              mem_we;
  logic [CUR_W-1:0]  mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [CUR_W-1:0]  mem_raddr;

  logic                    accept;
  logic                    slot_free;
  logic                    idx_ok;
  logic signed [TGT_W-1:0] seek_base;
  logic signed [TGT_W-1:0] seek_tgt;
  logic                    seek_ok;

  tcw_cd_req_t cd_req;
  tcw_cd_rsp_t cd_rsp;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign idx_ok     = (idx_q < POS_W'(CELL_COUNT));

  // Seek target: origin base plus the sign-extended offset.
  always_comb begin
    case (origin_q)
      ORG_CUR: seek_base = signed'(TGT_W'(cur_q));
      ORG_END: seek_base = TGT_W'(CELL_COUNT);
      default: seek_base = '0;
    endcase
    seek_tgt = seek_base + TGT_W'(off_q);
    seek_ok  = !seek_tgt[TGT_W-1] && (seek_tgt < TGT_W'(CELL_COUNT));
  end

  assign cd_req.start = (state_q == S_SEEK) && (origin_q != ORG_BAD) && seek_ok;
  assign cd_req.pos   = seek_tgt[CUR_W-1:0];

  tcw_col_unit u_col_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cd_req),
    .rsp_o  (cd_rsp)
  );

  // Memory port control. The scroll copy reads a cell one row down and
  // writes it one row up in the next cycle, once the registered read data is there.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_q;
    mem_wdata = {text_color_q, BLANK_CHAR};
    mem_raddr = CUR_W'(idx_q);
    unique case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = {RESET_COLOR, BLANK_CHAR};
      end
      S_CLR, S_SCR_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
      end
      S_WCELL: begin
        // A tab writes spaces whatever character code it came with.
        mem_we    = 1'b1;
        mem_wdata = {text_color_q, is_tab_q ? BLANK_CHAR : ch_q};
      end
      S_BS: begin
        mem_we    = (cur_q != '0);
        mem_waddr = cur_q - CUR_W'(1);
      end
      S_SCR_COPY: begin
        mem_we    = pend_q;
        mem_waddr = pend_addr_q;
        mem_wdata = rd_data_q;
        mem_raddr = cnt_q + CUR_W'(COLUMNS);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= screen_mem[mem_raddr];
  end

  // The color register takes a write on any cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= RESET_COLOR;
    end else if (cfg_we_i) begin
      text_color_q <= cfg_text_color_i;
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      cur_q        <= '0;
      col_q        <= '0;
      ph_q         <= '0;
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      pend_addr_q  <= '0;
      tab_n_q      <= '0;
      is_tab_q     <= 1'b0;
      ch_q         <= '0;
      off_q        <= '0;
      origin_q     <= ORG_START;
      idx_q        <= '0;
      status_q     <= ST_OK;
      scr_q        <= 1'b0;
      rd_char_q    <= '0;
      rd_color_q   <= '0;
      out_valid_q  <= 1'b0;
      cursor_pos_q <= '0;
      status_out_q <= ST_OK;
      scrolled_q   <= 1'b0;
      cell_char_q  <= '0;
      cell_color_q <= '0;
    end else begin
      // In S_DONE a taken beat is always replaced by the new result.
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT: begin
          if (cnt_q == CUR_W'(CELL_COUNT - 1)) begin
            cnt_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q + CUR_W'(1);
          end
        end

        S_IDLE: begin
          if (accept) begin
            ch_q       <= char_code_i;
            off_q      <= seek_offset_i;
            origin_q   <= origin_e'(seek_origin_i);
            idx_q      <= cell_index_i;
            status_q   <= ST_OK;
            scr_q      <= 1'b0;
            rd_char_q  <= '0;
            rd_color_q <= '0;
            is_tab_q   <= (kind_e'(kind_i) == KIND_PUT) && (char_code_i == CH_TAB);
            tab_n_q    <= '0;
            cnt_q      <= '0;
            pend_q     <= 1'b0;
            unique case (kind_e'(kind_i))
              KIND_PUT: begin
                unique case (char_code_i)
                  CH_NL: begin
                    // Newline from the last row scrolls; otherwise jump a row.
                    if (cur_q >= CUR_W'(LAST_ROW_HOME)) begin
                      state_q <= S_SCR_COPY;
                    end else begin
                      cur_q   <= cur_q + (CUR_W'(COLUMNS) - CUR_W'(col_q));
                      col_q   <= '0;
                      ph_q    <= '0;
                      state_q <= S_DONE;
                    end
                  end
                  CH_CR: begin
                    cur_q   <= cur_q - CUR_W'(col_q);
                    col_q   <= '0;
                    ph_q    <= '0;
                    state_q <= S_DONE;
                  end
                  CH_BS: state_q <= S_BS;
                  CH_TAB: state_q <= S_WCELL;
                  default: state_q <= S_WCELL;
                endcase
              end
              KIND_SEEK: state_q <= S_SEEK;
              KIND_REWIND: begin
                cur_q   <= '0;
                col_q   <= '0;
                ph_q    <= '0;
                state_q <= S_DONE;
              end
              KIND_CLEAR: state_q <= S_CLR;
              KIND_READ:  state_q <= S_READ;
              default:    state_q <= S_DONE;
            endcase
          end
        end

        S_WCELL: begin
          // The cell is written this cycle; then advance, scrolling off the end.
          if (cur_q == CUR_W'(CELL_COUNT - 1)) begin
            cnt_q   <= '0;
            pend_q  <= 1'b0;
            state_q <= S_SCR_COPY;
          end else begin
            cur_q <= cur_q + CUR_W'(1);
            if (col_q == COL_W'(COLUMNS - 1)) begin
              col_q <= '0;
              ph_q  <= '0;
            end else begin
              col_q <= col_q + COL_W'(1);
              ph_q  <= (ph_q == PH_W'(TAB_STOP - 1)) ? '0 : ph_q + PH_W'(1);
            end
            state_q <= is_tab_q ? S_TAB : S_DONE;
          end
        end

        S_TAB: begin
          if ((tab_n_q == TN_W'(TAB_STOP)) || (ph_q == '0)) begin
            state_q <= S_DONE;
          end else begin
            tab_n_q <= tab_n_q + TN_W'(1);
            state_q <= S_WCELL;
          end
        end

        S_BS: begin
          if (cur_q != '0) begin
            cur_q <= cur_q - CUR_W'(1);
            if (col_q == '0) begin
              col_q <= COL_W'(COLUMNS - 1);
              ph_q  <= PH_W'(PH_LAST);
            end else begin
              col_q <= col_q - COL_W'(1);
              ph_q  <= (ph_q == '0) ? PH_W'(TAB_STOP - 1) : ph_q - PH_W'(1);
            end
          end
          state_q <= S_DONE;
        end

        S_SCR_COPY: begin
          if (cnt_q < CUR_W'(LAST_ROW_HOME)) begin
            pend_q      <= 1'b1;
            pend_addr_q <= cnt_q;
            cnt_q       <= cnt_q + CUR_W'(1);
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              state_q <= S_SCR_BLANK;
            end
          end
        end

        S_SCR_BLANK: begin
          if (cnt_q == CUR_W'(CELL_COUNT - 1)) begin
            cur_q   <= CUR_W'(LAST_ROW_HOME);
            col_q   <= '0;
            ph_q    <= '0;
            scr_q   <= 1'b1;
            state_q <= is_tab_q ? S_TAB : S_DONE;
          end else begin
            cnt_q <= cnt_q + CUR_W'(1);
          end
        end

        S_SEEK: begin
          if (origin_q == ORG_BAD) begin
            status_q <= ST_BAD_ORIGIN;
            state_q  <= S_DONE;
          end else if (!seek_ok) begin
            status_q <= ST_RANGE;
            state_q  <= S_DONE;
          end else begin
            cur_q   <= seek_tgt[CUR_W-1:0];
            state_q <= S_SEEK_WAIT;
          end
        end

        S_SEEK_WAIT: begin
          if (cd_rsp.done) begin
            col_q   <= cd_rsp.col;
            ph_q    <= cd_rsp.ph;
            state_q <= S_DONE;
          end
        end

        S_CLR: begin
          if (cnt_q == CUR_W'(CELL_COUNT - 1)) begin
            cur_q   <= '0;
            col_q   <= '0;
            ph_q    <= '0;
            scr_q   <= 1'b1;
            state_q <= S_DONE;
          end else begin
            cnt_q <= cnt_q + CUR_W'(1);
          end
        end

        S_READ: begin
          state_q <= idx_ok ? S_READ_WAIT : S_DONE;
        end

        S_READ_WAIT: begin
          rd_char_q  <= rd_data_q[CHAR_W-1:0];
          rd_color_q <= rd_data_q[CELL_W-1:CHAR_W];
          state_q    <= S_DONE;
        end

        S_DONE: begin
          if (slot_free) begin
            out_valid_q  <= 1'b1;
            cursor_pos_q <= POS_W'(cur_q);
            status_out_q <= status_q;
            scrolled_q   <= scr_q;
            cell_char_q  <= rd_char_q;
            cell_color_q <= rd_color_q;
            state_q      <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_pos_o = cursor_pos_q;
  assign status_o     = status_out_q;
  assign scrolled_o   = scrolled_q;
  assign cell_char_o  = cell_char_q;
  assign cell_color_o = cell_color_q;

endmodule

`default_nettype wire

// File: tb/tb_text_console_writer.sv
// Self-checking testbench for the text console writer with a per-item screen predictor.
module tb_text_console_writer;
  import tcw_pkg::*;

  // Timing of the run. The slowest correct run has every item scroll the screen,
  // which costs a full sweep of the screen memory, plus receiver stalls and sender
  // gaps. For about 1360 items the limit leaves a wide margin on top of that and of
  // the clearing pass after reset.
  localparam int CLK_PERIOD       = 8;
  localparam int CYCLE_LIMIT      = 15_000_000;
  localparam int RANDOM_PER_PHASE = 335;
  localparam int END_SETTLE       = 200;

  // Kind codes that the block does not use; they must leave the screen alone.
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic [CHAR_W-1:0]          ch;
    logic signed [OFF_W-1:0]    off;
    logic [ORIGIN_W-1:0]        origin;
    logic [POS_W-1:0]           idx;
  } console_cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]    cursor;
    logic [STATUS_W-1:0] status;
    logic                scrolled;
    logic [CHAR_W-1:0]   rd_char;
    logic [COLOR_W-1:0]  rd_color;
  } console_resp_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

  // Signals of the block. Every input is known from time zero.
  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     cfg_we      = 1'b0;
  logic [COLOR_W-1:0]       cfg_color   = '0;
  logic                     in_valid    = 1'b0;
  logic                     in_stall;
  logic [KIND_W-1:0]        kind        = '0;
  logic [CHAR_W-1:0]        char_code   = '0;
  logic signed [OFF_W-1:0]  seek_offset = '0;
  logic [ORIGIN_W-1:0]      seek_origin = '0;
  logic [POS_W-1:0]         cell_index  = '0;
  logic                     out_valid;
  logic                     out_stall   = 1'b0;
  logic [POS_W-1:0]         cursor_pos;
  logic [STATUS_W-1:0]      status;
  logic                     scrolled;
  logic [CHAR_W-1:0]        cell_char;
  logic [COLOR_W-1:0]       cell_color;

  // Shadow copy of the console: screen cells as {color, char}, cursor and color.
  logic [CELL_W-1:0]  shadow_screen [CELL_COUNT];
  int                 shadow_cursor;
  logic [COLOR_W-1:0] shadow_color;
  logic               shadow_scrolled;

  console_cmd_t  queued_cmds[$];
  console_resp_t pending_results[$];

  int          mismatches   = 0;
  int unsigned cycle_count  = 0;
  logic        in_beat_seen = 1'b0;
  int          burst_left   = 1;
  int          gap_left     = 0;
  int          stall_run    = 0;
  stall_mode_e stall_mode   = STALL_NONE;

  text_console_writer uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_text_color_i (cfg_color),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .kind_i           (kind),
    .char_code_i      (char_code),
    .seek_offset_i    (seek_offset),
    .seek_origin_i    (seek_origin),
    .cell_index_i     (cell_index),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .cursor_pos_o     (cursor_pos),
    .status_o         (status),
    .scrolled_o       (scrolled),
    .cell_char_o      (cell_char),
    .cell_color_o     (cell_color)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Screen predictor.
  // ---------------------------------------------------------------------------

  // Once the cursor runs past the last cell, every row moves up by one, the
  // bottom row turns blank in the current color and the cursor goes to the
  // start of the bottom row.
  task automatic scroll_if_past_end();
    if (shadow_cursor >= CELL_COUNT) begin
      for (int i = 0; i < LAST_ROW_HOME; i++) shadow_screen[i] = shadow_screen[i + COLUMNS];
      for (int i = LAST_ROW_HOME; i < CELL_COUNT; i++)
        shadow_screen[i] = {shadow_color, BLANK_CHAR};
      shadow_cursor   = LAST_ROW_HOME;
      shadow_scrolled = 1'b1;
    end
  endtask

  task automatic place_char(input logic [CHAR_W-1:0] ch);
    if (shadow_cursor < CELL_COUNT) shadow_screen[shadow_cursor] = {shadow_color, ch};
    shadow_cursor++;
    scroll_if_past_end();
  endtask

  task automatic type_char(input logic [CHAR_W-1:0] ch);
    case (ch)
      CH_NL: begin
        shadow_cursor = (shadow_cursor / COLUMNS + 1) * COLUMNS;
        scroll_if_past_end();
      end
      CH_CR: begin
        shadow_cursor -= shadow_cursor % COLUMNS;
      end
      CH_BS: begin
        // Backspace in the very first cell has nothing to erase.
        if (shadow_cursor > 0) begin
          shadow_cursor--;
          shadow_screen[shadow_cursor] = {shadow_color, BLANK_CHAR};
        end
      end
      CH_TAB: begin
        // Always at least one space, then spaces until the column sits on a tab
        // stop. A space in the last cell scrolls, which lands on column zero.
        place_char(BLANK_CHAR);
        for (int n = 0; n < TAB_STOP; n++) begin
          if ((shadow_cursor % COLUMNS) % TAB_STOP == 0) break;
          place_char(BLANK_CHAR);
        end
      end
      default: begin
        place_char(ch);
      end
    endcase
  endtask

  task automatic predict_console(input console_cmd_t c, output console_resp_t r);
    int target;
    r               = '0;
    shadow_scrolled = 1'b0;
    case (c.kind)
      KIND_PUT: begin
        type_char(c.ch);
      end
      KIND_SEEK: begin
        // Bad origin and out-of-range targets leave the cursor where it was.
        if (c.origin == ORG_BAD) begin
          r.status = ST_BAD_ORIGIN;
        end else begin
          case (c.origin)
            ORG_START: target = $signed(c.off);
            ORG_CUR:   target = shadow_cursor + $signed(c.off);
            default:   target = CELL_COUNT + $signed(c.off);
          endcase
          if (target >= 0 && target < CELL_COUNT) shadow_cursor = target;
          else r.status = ST_RANGE;
        end
      end
      KIND_REWIND: begin
        shadow_cursor = 0;
      end
      KIND_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++) shadow_screen[i] = {shadow_color, BLANK_CHAR};
        shadow_cursor   = 0;
        shadow_scrolled = 1'b1;
      end
      KIND_READ: begin
        // Reads past the end of the screen return zeros.
        if (c.idx < CELL_COUNT) {r.rd_color, r.rd_char} = shadow_screen[c.idx];
      end
      default: begin
      end
    endcase
    r.cursor   = POS_W'(shadow_cursor);
    r.scrolled = shadow_scrolled;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------

  function automatic console_cmd_t make_cmd(input logic [KIND_W-1:0] k,
                                            input logic [CHAR_W-1:0] ch, input int off,
                                            input logic [ORIGIN_W-1:0] origin, input int idx);
    console_cmd_t c;
    c.kind   = k;
    c.ch     = ch;
    c.off    = OFF_W'(off);
    c.origin = origin;
    c.idx    = POS_W'(idx);
    return c;
  endfunction

  // Mostly ordinary text with control characters, seeks and reads mixed in;
  // a small share is unused kinds and fully random items. Fields that the kind
  // does not use still carry random values.
  function automatic console_cmd_t random_console_cmd();
    console_cmd_t c;
    int unsigned  pick;
    int           off;
    c.kind   = KIND_W'($urandom_range(KIND_PUT, KIND_UNUSED_HI));
    c.ch     = CHAR_W'($urandom_range(0, 255));
    off      = int'($urandom_range(0, 8191)) - 4096;
    c.off    = OFF_W'(off);
    c.origin = ORIGIN_W'($urandom_range(ORG_START, ORG_BAD));
    c.idx    = POS_W'($urandom_range(0, 2047));
    pick     = $urandom_range(0, 99);
    if (pick < 40) begin
      c.kind = KIND_PUT;
      c.ch   = CHAR_W'($urandom_range(32, 126));
    end else if (pick < 45) begin
      c.kind = KIND_PUT;
    end else if (pick < 51) begin
      c.kind = KIND_PUT;
      c.ch   = CH_NL;
    end else if (pick < 54) begin
      c.kind = KIND_PUT;
      c.ch   = CH_CR;
    end else if (pick < 59) begin
      c.kind = KIND_PUT;
      c.ch   = CH_BS;
    end else if (pick < 65) begin
      c.kind = KIND_PUT;
      c.ch   = CH_TAB;
    end else if (pick < 75) begin
      c.kind = KIND_SEEK;
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          c.origin = ORG_START;
          off      = int'($urandom_range(0, CELL_COUNT + 40)) - 20;
        end
        3, 4, 5: begin
          c.origin = ORG_CUR;
          off      = int'($urandom_range(0, 200)) - 100;
        end
        6, 7: begin
          c.origin = ORG_END;
          off      = int'($urandom_range(0, CELL_COUNT + 20)) - (CELL_COUNT + 10);
        end
        8: begin
          c.origin = ORG_BAD;
        end
        default: begin
        end
      endcase
      c.off = OFF_W'(off);
    end else if (pick < 78) begin
      c.kind = KIND_REWIND;
    end else if (pick < 80) begin
      c.kind = KIND_CLEAR;
    end else if (pick < 96) begin
      c.kind = KIND_READ;
      if ($urandom_range(0, 15) == 0) c.idx = POS_W'($urandom_range(CELL_COUNT - 1, 2047));
      else c.idx = POS_W'($urandom_range(0, CELL_COUNT - 1));
    end else if (pick < 98) begin
      c.kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    end
    return c;
  endfunction

  task automatic load_directed();
    queued_cmds.push_back(make_cmd(KIND_READ, 8'h00, 0, ORG_START, 0));
    queued_cmds.push_back(make_cmd(KIND_PUT, 8'h41, 0, ORG_START, 0));
    queued_cmds.push_back(make_cmd(KIND_PUT, 8'h00, 0, ORG_START, 0));
    queued_cmds.push_back(make_cmd(KIND_PUT, 8'hFF, -1, ORG_BAD, 2047));
    queued_cmds.push_back(make_cmd(KIND_PUT, CH_BS, 0, ORG_START, 0));
    queued_cmds.push_back(make_cmd(KIND_PUT, CH_TAB, 0, ORG_START, 0));
    queued_cmds.push_back(make_cmd(KIND_PUT, CH_CR, 0, ORG_START, 0));
    queued_cmds.push_back(make_cmd(KIND_PUT, CH_NL, 0, ORG_START, 0));
    queued_cmds.push_back(make_cmd(KIND_REWIND, 8'h00, 0, ORG_START, 0));
    queued_cmds.push_back(make_cmd(KIND_PUT, CH_BS, 0, ORG_START, 0));
    // Last cell, then a character there scrolls the screen.
    queued_cmds.push_back(make_cmd(KIND_SEEK, 8'h00, CELL_COUNT - 1, ORG_START, 0));
    queued_cmds.push_back(make_cmd(KIND_PUT, 8'h5A, 0, ORG_START, 0));
    queued_cmds.push_back(make_cmd(KIND_SEEK, 8'h00, 5, ORG_BAD, 0));
    queued_cmds.push_back(make_cmd(KIND_SEEK, 8'h00, -4096, ORG_CUR, 0));
    queued_cmds.push_back(make_cmd(KIND_SEEK, 8'h00, -1, ORG_END, 0));
    queued_cmds.push_back(make_cmd(KIND_PUT, CH_NL, 0, ORG_START, 0));
    queued_cmds.push_back(make_cmd(KIND_SEEK, 8'h00, 4095, ORG_END, 0));
    queued_cmds.push_back(make_cmd(KIND_SEEK, 8'h00, CELL_COUNT, ORG_START, 0));
    queued_cmds.push_back(make_cmd(KIND_SEEK, 8'h00, 5, ORG_CUR, 0));
    // A tab that starts two cells before the end spills over and scrolls.
    queued_cmds.push_back(make_cmd(KIND_SEEK, 8'h00, CELL_COUNT - 2, ORG_START, 0));
    queued_cmds.push_back(make_cmd(KIND_PUT, CH_TAB, 0, ORG_START, 0));
    queued_cmds.push_back(make_cmd(KIND_READ, 8'h00, 0, ORG_START, 2047));
    queued_cmds.push_back(make_cmd(KIND_READ, 8'h00, 0, ORG_START, CELL_COUNT - COLUMNS - 1));
    queued_cmds.push_back(make_cmd(KIND_UNUSED_LO, 8'h41, 0, ORG_START, 0));
    queued_cmds.push_back(make_cmd(KIND_UNUSED_HI, 8'h41, 0, ORG_START, 0));
    queued_cmds.push_back(make_cmd(KIND_CLEAR, 8'h00, 0, ORG_START, 0));
  endtask

  // Waits until every queued item has gone in and every result is back.
  task automatic wait_for_drain();
    while (queued_cmds.size() != 0 || in_valid || pending_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, separated by random gaps. The payload only
  // changes after its beat has been taken. Valid and payload are updated at once
  // so that the drain check never sees an item popped but not yet driven.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : driver
    console_cmd_t head_cmd;
    if (!in_valid || in_beat_seen) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid = 1'b0;
      end else if (queued_cmds.size() > 0) begin
        head_cmd = queued_cmds.pop_front();
        kind        = head_cmd.kind;
        char_code   = head_cmd.ch;
        seek_offset = head_cmd.off;
        seek_origin = head_cmd.origin;
        cell_index  = head_cmd.idx;
        in_valid    = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 30);
          if ($urandom_range(0, 3) == 0) gap_left = 0;
          else if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(7, 40);
          else gap_left = $urandom_range(1, 6);
        end
      end else begin
        in_valid = 1'b0;
      end
    end
  end

  // Receiver: the stall pattern switches between no stall, light, heavy and
  // alternating stalls, each kept for a random stretch of cycles.
  always @(negedge clk) begin : stall_pattern
    if (stall_run == 0) begin
      stall_mode = stall_mode_e'($urandom_range(STALL_NONE, STALL_TOGGLE));
      stall_run  = $urandom_range(16, 256);
    end
    stall_run--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ~out_stall;
    endcase
  end

  // Monitor: tracks color writes, checks result beats against the oldest
  // prediction and predicts every accepted input beat.
  always @(posedge clk) begin : monitor
    console_resp_t got;
    console_resp_t want;
    console_resp_t fresh;
    in_beat_seen = 1'b0;
    if (rst_n) begin
      if (cfg_we) shadow_color = cfg_color;
      if (out_valid && !out_stall) begin
        got = {cursor_pos, status, scrolled, cell_char, cell_color};
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result beat expected none actual cursor_pos %0d status %0d",
                   $time, got.cursor, got.status);
        end else begin
          want = pending_results.pop_front();
          check_field("cursor_pos", want.cursor, got.cursor);
          check_field("status", want.status, got.status);
          check_field("scrolled", want.scrolled, got.scrolled);
          check_field("cell_char", want.rd_char, got.rd_char);
          check_field("cell_color", want.rd_color, got.rd_color);
        end
      end
      in_beat_seen = in_valid && !in_stall;
      if (in_beat_seen) begin
        predict_console({kind, char_code, seek_offset, seek_origin, cell_index}, fresh);
        pending_results.push_back(fresh);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Main sequence: reset, a directed pass in the reset color, then random
  // phases, each under its own color. Between phases the sender waits until
  // every result is back, so the color only changes while the block is idle.
  initial begin : sequencer
    logic [COLOR_W-1:0] phase_colors [4];
    phase_colors[0] = 8'h00;
    phase_colors[1] = 8'hFF;
    phase_colors[2] = COLOR_W'($urandom_range(1, 254));
    phase_colors[3] = COLOR_W'($urandom_range(0, 255));

    for (int i = 0; i < CELL_COUNT; i++) shadow_screen[i] = {RESET_COLOR, BLANK_CHAR};
    shadow_cursor   = 0;
    shadow_color    = RESET_COLOR;
    shadow_scrolled = 1'b0;

    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    load_directed();
    for (int p = 0; p < 4; p++) begin
      wait_for_drain();
      cfg_color = phase_colors[p];
      cfg_we    = 1'b1;
      @(negedge clk);
      cfg_we    = 1'b0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) queued_cmds.push_back(random_console_cmd());
    end
    wait_for_drain();
    repeat (END_SETTLE) @(negedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
